// ===== rtl/ring_deque_with_indexed_insert_core_assert.svh =====
// assertion macros for the ring deque core
`ifndef RING_DEQUE_WITH_INDEXED_INSERT_CORE_ASSERT_SVH
`define RING_DEQUE_WITH_INDEXED_INSERT_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RDQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rdq assertion failed");

// next-cycle implication, disabled during reset
`define RDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rdq assertion failed");

`endif

// ===== rtl/rdq_pkg.sv =====
// types and codes shared by the ring deque core and its cells
package rdq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT_AT  = 3'd4,
    CMD_ERASE_AT   = 3'd5
  } rdq_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } rdq_status_e;

  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_SHIFT_UP   = 2'd1,
    OP_SHIFT_DOWN = 2'd2,
    OP_LOAD       = 2'd3
  } rdq_op_e;

endpackage

// ===== rtl/rdq_cell.sv =====
// one storage cell of the deque row, loads or takes a word from a neighbor
module rdq_cell #(
  parameter int WordW = 32
) (
  input  logic               clk_i,
  input  rdq_pkg::rdq_op_e   op_i,
  input  logic [WordW-1:0]   lower_i,
  input  logic [WordW-1:0]   upper_i,
  input  logic [WordW-1:0]   load_i,
  output logic [WordW-1:0]   word_o
);
  import rdq_pkg::*;

  logic [WordW-1:0] word_q;
  logic [WordW-1:0] word_d;

  always_comb begin
    case (op_i)
      OP_SHIFT_UP:   word_d = lower_i;
      OP_SHIFT_DOWN: word_d = upper_i;
      OP_LOAD:       word_d = load_i;
      default:       word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== rtl/ring_deque_with_indexed_insert_core.sv =====
// ring deque core: command decode, cell row, count and result register
//
// Deque of up to DEPTH-1 words in logical order in a row of DEPTH cells, cell
// 0 being the front. Inserts, pushes, erases and front pops move all cells at
// and above the index toward or away from it at once; a back pop only lowers
// the count. The result is registered, so a command is answered in the cycle
// after it is taken; a new command is taken whenever the result register is
// empty or being drained in the same cycle, giving one command per cycle while
// results are drained. Full pushes and inserts, empty pops and out-of-range
// indices change nothing, report their status and give the entry count after.
module ring_deque_with_indexed_insert_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  position_i,
  input  logic [31:0] data_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] data_out_o,
  output logic [3:0]  count_o
);
  import rdq_pkg::*;

  localparam int CntW  = $clog2(DEPTH);
  localparam int CmpW  = (CntW > 4) ? CntW : 4;
  localparam int WordW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] word_q [DEPTH];
  rdq_op_e          op    [DEPTH];

  logic             fire;
  logic             ins, ers;
  logic [CntW-1:0]  at;
  logic [CmpW-1:0]  cnt_ext, pos_ext;
  logic             full, empty;
  rdq_status_e      status;
  logic [WordW-1:0] data;

  logic             out_valid_q;
  rdq_status_e      status_q;
  logic [31:0]      data_q;
  logic [3:0]       count_q;

  assign fire       = in_valid_i & in_ready_o;
  assign in_ready_o = ~out_valid_q | out_ready_i;

  assign cnt_ext = CmpW'(cnt_q);
  assign pos_ext = CmpW'(position_i);
  assign full    = (cnt_q == CntW'(DEPTH - 1));
  assign empty   = (cnt_q == '0);

  always_comb begin
    ins    = 1'b0;
    ers    = 1'b0;
    at     = '0;
    status = ST_OK;
    data   = '0;
    cnt_d  = cnt_q;
    case (rdq_cmd_e'(cmd_i))
      CMD_PUSH_BACK: begin
        if (full) status = ST_FULL;
        else begin
          ins = 1'b1;
          at  = cnt_q;
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) status = ST_FULL;
        else ins = 1'b1;
      end
      CMD_POP_FRONT: begin
        if (empty) status = ST_EMPTY;
        else begin
          ers  = 1'b1;
          data = word_q[0];
        end
      end
      CMD_POP_BACK: begin
        if (empty) status = ST_EMPTY;
        else begin
          data  = word_q[cnt_q - 1'b1];
          cnt_d = cnt_q - 1'b1;
        end
      end
      CMD_INSERT_AT: begin
        if (pos_ext > cnt_ext) status = ST_RANGE;
        else if (full) status = ST_FULL;
        else begin
          ins = 1'b1;
          at  = pos_ext[CntW-1:0];
        end
      end
      CMD_ERASE_AT: begin
        if (pos_ext >= cnt_ext) status = ST_RANGE;
        else begin
          ers = 1'b1;
          at  = pos_ext[CntW-1:0];
        end
      end
      default: ;
    endcase
    if (ins) cnt_d = cnt_q + 1'b1;
    if (ers) cnt_d = cnt_q - 1'b1;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] lower, upper;

    if (i == 0) begin : g_first
      assign lower = data_in_i[WordW-1:0];
    end else begin : g_mid
      assign lower = word_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = word_q[i];
    end else begin : g_inner
      assign upper = word_q[i+1];
    end

    always_comb begin
      op[i] = OP_HOLD;
      if (fire && ins) begin
        if (CntW'(i) == at) op[i] = OP_LOAD;
        else if (CntW'(i) > at) op[i] = OP_SHIFT_UP;
      end else if (fire && ers && (CntW'(i) >= at)) begin
        op[i] = OP_SHIFT_DOWN;
      end
    end

    rdq_cell #(
      .WordW (WordW)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op[i]),
      .lower_i (lower),
      .upper_i (upper),
      .load_i  (data_in_i[WordW-1:0]),
      .word_o  (word_q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status;
      data_q   <= 32'(data);
      count_q  <= 4'(CmpW'(cnt_d));
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = data_q;
  assign count_o     = count_q;

`include "ring_deque_with_indexed_insert_core_assert.svh"

  `RDQ_ASSERT_NEXT(a_push_grows, fire && ins, cnt_q == $past(cnt_q) + 1'b1)
  `RDQ_ASSERT_NEXT(a_erase_shrinks, fire && ers, cnt_q == $past(cnt_q) - 1'b1)
  `RDQ_ASSERT_IMPL(a_empty_count, out_valid_o && (status_o == ST_EMPTY), count_o == 4'd0)
  `RDQ_ASSERT_IMPL(a_refused_keeps, fire && (status != ST_OK), cnt_d == cnt_q)

endmodule
